>>> rtl/pnoise1d_pkg.sv
// Shared constants, permutation table and fade coefficients for the 1-D gradient noise core.
`timescale 1ns / 1ps

package pnoise1d_pkg;

  // Default number of fraction bits of the position and the result.
  localparam int unsigned FRAC_BITS_DEF = 16;

  // Width of the position word.
  localparam int unsigned POS_W = 32;

  // Width of a table index and of a hash.
  localparam int unsigned IDX_W  = 8;
  localparam int unsigned HASH_W = 4;

  // Coefficients of the quintic fade in Horner form: f^3 * (10 - f * (15 - 6f)).
  localparam logic [3:0] FADE_K15 = 4'd15;
  localparam logic [2:0] FADE_K6  = 3'd6;
  localparam logic [3:0] FADE_K10 = 4'd10;

  // Gradient magnitude is one plus the low three hash bits.
  localparam logic [2:0] GRAD_MAG_MASK = 3'd7;

  localparam logic [IDX_W-1:0] PERM_ROM [256] = '{
    8'd151, 8'd160, 8'd137, 8'd91,  8'd90,  8'd15,  8'd131, 8'd13,
    8'd201, 8'd95,  8'd96,  8'd53,  8'd194, 8'd233, 8'd7,   8'd225,
    8'd140, 8'd36,  8'd103, 8'd30,  8'd69,  8'd142, 8'd8,   8'd99,
    8'd37,  8'd240, 8'd21,  8'd10,  8'd23,  8'd190, 8'd6,   8'd148,
    8'd247, 8'd120, 8'd234, 8'd75,  8'd0,   8'd26,  8'd197, 8'd62,
    8'd94,  8'd252, 8'd219, 8'd203, 8'd117, 8'd35,  8'd11,  8'd32,
    8'd57,  8'd177, 8'd33,  8'd88,  8'd237, 8'd149, 8'd56,  8'd87,
    8'd174, 8'd20,  8'd125, 8'd136, 8'd171, 8'd168, 8'd68,  8'd175,
    8'd74,  8'd165, 8'd71,  8'd134, 8'd139, 8'd48,  8'd27,  8'd166,
    8'd77,  8'd146, 8'd158, 8'd231, 8'd83,  8'd111, 8'd229, 8'd122,
    8'd60,  8'd211, 8'd133, 8'd230, 8'd220, 8'd105, 8'd92,  8'd41,
    8'd55,  8'd46,  8'd245, 8'd40,  8'd244, 8'd102, 8'd143, 8'd54,
    8'd65,  8'd25,  8'd63,  8'd161, 8'd1,   8'd216, 8'd80,  8'd73,
    8'd209, 8'd76,  8'd132, 8'd187, 8'd208, 8'd89,  8'd18,  8'd169,
    8'd200, 8'd196, 8'd135, 8'd130, 8'd116, 8'd188, 8'd159, 8'd86,
    8'd164, 8'd100, 8'd109, 8'd198, 8'd173, 8'd186, 8'd3,   8'd64,
    8'd52,  8'd217, 8'd226, 8'd250, 8'd124, 8'd123, 8'd5,   8'd202,
    8'd38,  8'd147, 8'd118, 8'd126, 8'd255, 8'd82,  8'd85,  8'd212,
    8'd207, 8'd206, 8'd59,  8'd227, 8'd47,  8'd16,  8'd58,  8'd17,
    8'd182, 8'd189, 8'd28,  8'd42,  8'd223, 8'd183, 8'd170, 8'd213,
    8'd119, 8'd248, 8'd152, 8'd2,   8'd44,  8'd154, 8'd163, 8'd70,
    8'd221, 8'd153, 8'd101, 8'd155, 8'd167, 8'd43,  8'd172, 8'd9,
    8'd129, 8'd22,  8'd39,  8'd253, 8'd19,  8'd98,  8'd108, 8'd110,
    8'd79,  8'd113, 8'd224, 8'd232, 8'd178, 8'd185, 8'd112, 8'd104,
    8'd218, 8'd246, 8'd97,  8'd228, 8'd251, 8'd34,  8'd242, 8'd193,
    8'd238, 8'd210, 8'd144, 8'd12,  8'd191, 8'd179, 8'd162, 8'd241,
    8'd81,  8'd51,  8'd145, 8'd235, 8'd249, 8'd14,  8'd239, 8'd107,
    8'd49,  8'd192, 8'd214, 8'd31,  8'd181, 8'd199, 8'd106, 8'd157,
    8'd184, 8'd84,  8'd204, 8'd176, 8'd115, 8'd121, 8'd50,  8'd45,
    8'd127, 8'd4,   8'd150, 8'd254, 8'd138, 8'd236, 8'd205, 8'd93,
    8'd222, 8'd114, 8'd67,  8'd29,  8'd24,  8'd72,  8'd243, 8'd141,
    8'd128, 8'd195, 8'd78,  8'd66,  8'd215, 8'd61,  8'd156, 8'd180
  };

endpackage

>>> rtl/perlin_noise_1d_core.sv
// One-dimensional gradient noise core: six-stage pipeline from position word to noise word.
`timescale 1ns / 1ps

// The core takes a signed fixed-point position word (FracBits fraction bits) and returns for
// it one signed noise word with FracBits fraction bits and four integer bits, magnitude at
// most 8.0. Each word passes through six register stages (table lookup, fade and gradients,
// fade cubic term, fade product, blend product, final add into the output register) in that
// order. One word is taken every cycle while the output accepts or a stage is empty; stage
// valid bits let bubbles close up, so the input side stays ready while any stage is empty
// even when the output is stalled. Words are independent and the core keeps no state
// between them.
module perlin_noise_1d_core #(
  parameter int unsigned FracBits = pnoise1d_pkg::FRAC_BITS_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  s_axis_tvalid_i,
  output logic                                  s_axis_tready_o,
  // [31:0] position
  input  logic [pnoise1d_pkg::POS_W-1:0]        s_axis_tdata_i,
  output logic                                  m_axis_tvalid_o,
  input  logic                                  m_axis_tready_i,
  // [FracBits+4:0] noise, zero padding above
  output logic [((FracBits+12)/8)*8-1:0]        m_axis_tdata_o
);
  import pnoise1d_pkg::*;

  localparam int unsigned NoiseW = FracBits + 5;
  localparam int unsigned OutW   = ((FracBits + 12) / 8) * 8;

  localparam logic [FracBits+3:0] OneFx     = (FracBits+4)'(1) << FracBits;
  localparam logic [FracBits+3:0] FifteenFx = (FracBits+4)'(FADE_K15) << FracBits;
  localparam logic [FracBits+3:0] TenFx     = (FracBits+4)'(FADE_K10) << FracBits;

  // Stage enables: a stage loads when it is empty or the next one loads.
  logic en1, en2, en3, en4, en5, en6;
  logic v1_q, v2_q, v3_q, v4_q, v5_q, vout_q;

  assign en6 = !vout_q || m_axis_tready_i;
  assign en5 = !v5_q || en6;
  assign en4 = !v4_q || en5;
  assign en3 = !v3_q || en4;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;

  assign s_axis_tready_o = en1;
  assign m_axis_tvalid_o = vout_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      v3_q   <= 1'b0;
      v4_q   <= 1'b0;
      v5_q   <= 1'b0;
      vout_q <= 1'b0;
    end else begin
      if (en1) v1_q   <= s_axis_tvalid_i;
      if (en2) v2_q   <= v1_q;
      if (en3) v3_q   <= v2_q;
      if (en4) v4_q   <= v3_q;
      if (en5) v5_q   <= v4_q;
      if (en6) vout_q <= v5_q;
    end
  end

  // Stage 1: split the position and look up both hashes.
  logic [FracBits-1:0] frac_in;
  logic [IDX_W-1:0]    idx_a, idx_b;
  logic [IDX_W-1:0]    perm_a, perm_b;

  assign frac_in = s_axis_tdata_i[FracBits-1:0];
  assign idx_a   = s_axis_tdata_i[FracBits+IDX_W-1:FracBits];
  assign idx_b   = idx_a + IDX_W'(1);
  assign perm_a  = PERM_ROM[idx_a];
  assign perm_b  = PERM_ROM[idx_b];

  logic [FracBits-1:0] f1_q;
  logic [HASH_W-1:0]   ha1_q, hb1_q;

  always_ff @(posedge clk_i) begin
    if (en1) begin
      f1_q  <= frac_in;
      ha1_q <= perm_a[HASH_W-1:0];
      hb1_q <= perm_b[HASH_W-1:0];
    end
  end

  // Stage 2: first fade product, f squared, and both gradient terms.
  logic [FracBits+3:0]     six_f, fifteen_minus;
  logic [2*FracBits+3:0]   p_full;
  logic [2*FracBits-1:0]   sq_full;
  logic [3:0]              mag_a, mag_b;
  logic [FracBits:0]       one_minus_f;
  logic [FracBits+4:0]     gma, gmb;
  logic signed [FracBits+4:0] ga_d, gb_d;

  assign six_f         = (FracBits+4)'(f1_q) * FADE_K6;
  assign fifteen_minus = FifteenFx - six_f;
  assign p_full        = f1_q * fifteen_minus;
  assign sq_full       = f1_q * f1_q;
  assign mag_a         = {1'b0, ha1_q[2:0] & GRAD_MAG_MASK} + 4'd1;
  assign mag_b         = {1'b0, hb1_q[2:0] & GRAD_MAG_MASK} + 4'd1;
  assign one_minus_f   = OneFx[FracBits:0] - {1'b0, f1_q};
  assign gma           = mag_a * f1_q;
  assign gmb           = mag_b * one_minus_f;
  // The far gradient multiplies f-1, which is negative, so its sign is flipped.
  assign ga_d          = ha1_q[3] ? -$signed(gma) : $signed(gma);
  assign gb_d          = hb1_q[3] ? $signed(gmb) : -$signed(gmb);

  logic [FracBits-1:0]        f2_q, sq2_q;
  logic [FracBits+3:0]        p2_q;
  logic signed [FracBits+4:0] ga2_q, gb2_q;

  always_ff @(posedge clk_i) begin
    if (en2) begin
      f2_q  <= f1_q;
      sq2_q <= sq_full[2*FracBits-1:FracBits];
      p2_q  <= p_full[2*FracBits+3:FracBits];
      ga2_q <= ga_d;
      gb2_q <= gb_d;
    end
  end

  // Stage 3: cubic term, fade polynomial tail and gradient difference.
  logic [FracBits+3:0]        c_d;
  logic [2*FracBits-1:0]      cube_full;
  logic signed [FracBits+5:0] diff;
  logic [FracBits+5:0]        diff_abs;

  assign c_d       = TenFx - p2_q;
  assign cube_full = sq2_q * f2_q;
  assign diff      = (FracBits+6)'(gb2_q) - (FracBits+6)'(ga2_q);
  assign diff_abs  = diff[FracBits+5] ? -diff : diff;

  logic [FracBits+3:0]        c3_q;
  logic [FracBits-1:0]        cube3_q;
  logic signed [FracBits+4:0] ga3_q;
  logic                       dneg3_q;
  logic [FracBits+4:0]        mag3_q;

  always_ff @(posedge clk_i) begin
    if (en3) begin
      c3_q    <= c_d;
      cube3_q <= cube_full[2*FracBits-1:FracBits];
      ga3_q   <= ga2_q;
      dneg3_q <= diff[FracBits+5];
      mag3_q  <= diff_abs[FracBits+4:0];
    end
  end

  // Stage 4: fade value, saturated to one.
  logic [2*FracBits+3:0] u_full;
  logic [FracBits+3:0]   u_raw;
  logic [FracBits:0]     u_d;

  assign u_full = cube3_q * c3_q;
  assign u_raw  = u_full[2*FracBits+3:FracBits];
  assign u_d    = (u_raw > OneFx) ? OneFx[FracBits:0] : u_raw[FracBits:0];

  logic [FracBits:0]          u4_q;
  logic signed [FracBits+4:0] ga4_q;
  logic                       dneg4_q;
  logic [FracBits+4:0]        mag4_q;

  always_ff @(posedge clk_i) begin
    if (en4) begin
      u4_q    <= u_d;
      ga4_q   <= ga3_q;
      dneg4_q <= dneg3_q;
      mag4_q  <= mag3_q;
    end
  end

  // Stage 5: blend product on the magnitude, truncated toward zero.
  logic [2*FracBits+5:0] blend_full;

  assign blend_full = u4_q * mag4_q;

  logic [FracBits+4:0]        pr5_q;
  logic signed [FracBits+4:0] ga5_q;
  logic                       dneg5_q;

  always_ff @(posedge clk_i) begin
    if (en5) begin
      pr5_q   <= blend_full[2*FracBits+4:FracBits];
      ga5_q   <= ga4_q;
      dneg5_q <= dneg4_q;
    end
  end

  // Stage 6: apply the sign and add the near gradient.
  logic signed [FracBits+5:0] pr_ext, noise_full;
  logic [NoiseW-1:0]          noise_q;

  assign pr_ext     = $signed({1'b0, pr5_q});
  assign noise_full = (FracBits+6)'(ga5_q) + (dneg5_q ? -pr_ext : pr_ext);

  always_ff @(posedge clk_i) begin
    if (en6) begin
      noise_q <= noise_full[NoiseW-1:0];
    end
  end

  assign m_axis_tdata_o = (OutW)'(noise_q);

endmodule

>>> rtl/pnoise1d_chk.sv
// Port checker for the 1-D gradient noise core, bound to the top level.
`timescale 1ns / 1ps

module pnoise1d_chk #(
  parameter int unsigned FracBits = pnoise1d_pkg::FRAC_BITS_DEF
) (
  input logic                                  clk_i,
  input logic                                  rst_ni,
  input logic                                  s_axis_tready_o,
  input logic                                  m_axis_tvalid_o,
  input logic                                  m_axis_tready_i,
  // [FracBits+4:0] noise, zero padding above
  input logic [((FracBits+12)/8)*8-1:0]        m_axis_tdata_o
);

  localparam int unsigned NoiseW   = FracBits + 5;
  localparam int unsigned OutW     = ((FracBits + 12) / 8) * 8;
  localparam int          NoiseMax = 1 << (FracBits + 3);

  logic signed [NoiseW-1:0] noise;
  assign noise = $signed(m_axis_tdata_o[NoiseW-1:0]);

  // A word waiting at the output stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("output word withdrawn while stalled");

  // A word waiting at the output keeps its value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> $stable(m_axis_tdata_o))
    else $error("output word changed while stalled");

  // With the output draining, the whole pipeline moves, so the input side is ready.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tready_i |-> s_axis_tready_o)
    else $error("input not ready although output is draining");

  // The noise value never leaves plus or minus eight.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (noise <= NoiseMax && noise >= -NoiseMax))
    else $error("noise word out of range");

  if (OutW > NoiseW) begin : g_pad
    // Bits above the noise field are padding and read as zero.
    assert property (@(posedge clk_i) disable iff (!rst_ni)
      m_axis_tvalid_o |-> m_axis_tdata_o[OutW-1:NoiseW] == '0)
      else $error("padding bits of output word not zero");
  end

endmodule

bind perlin_noise_1d_core pnoise1d_chk #(.FracBits(FracBits)) u_pnoise1d_chk (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);
